/* hw/rtl/pee_pkg.sv */
`default_nettype none

package pee_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_VALUE_WIDTH = 32;
    localparam int SYMBOL_WIDTH    = 8;
    localparam int FLAG_COUNT      = 4;

    localparam logic [SYMBOL_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYMBOL_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [SYMBOL_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_WIDTH-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYMBOL_WIDTH-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_MUL,
        AL_DIV,
        AL_SIGN,
        AL_DONE
    } alu_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_A,
        ST_POP_B,
        ST_LOAD,
        ST_EXEC,
        ST_FINAL,
        ST_EMIT
    } eval_state_t;

    function automatic logic is_digit(input logic [SYMBOL_WIDTH-1:0] sym);
        return (sym >= CH_ZERO) && (sym <= CH_NINE);
    endfunction

    function automatic logic is_operator(input logic [SYMBOL_WIDTH-1:0] sym);
        return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_STAR) ||
               (sym == CH_SLASH);
    endfunction

    function automatic alu_op_t decode_op(input logic [SYMBOL_WIDTH-1:0] sym);
        alu_op_t op;
        case (sym)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_ADD;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/prefix_expression_evaluator_unit.sv */
`default_nettype none

// Prefix expression evaluator. Characters of one expression arrive on the s_ stream
// right to left, one per beat, with s_tlast on the leftmost one. Digits push their
// value on an operand stack, + - * / pop two values and push first op second; all
// other characters are ignored. After the beat with s_tlast the result is popped and
// one beat leaves on the m_ stream: the value on m_tdata and four flags on m_tuser,
// three of them sticky. Stack and flags are then cleared for the next expression.
// Steps: a digit or an ignored character is handled as it is taken. An operator pops
// its two operands one after the other through the stack memory's read port, runs in
// the shared bit-serial multiply/divide unit (add and subtract also pass through it,
// and a zero divisor skips the division steps), then pushes the result. A last beat
// adds a final pop and the output step.
// s_tready is low while an item is in work. The output register holds a result
// until it is taken, so input keeps flowing while the receiver stalls; a further
// result waits in its final step until the register is free.
// Reset (aresetn low, synchronous) empties the stack, clears the flags and the
// output valid. The stack memory itself is not cleared and needs no clearing pass.

module prefix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [pee_pkg::SYMBOL_WIDTH-1:0]      s_tdata,  // [7:0] symbol
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [pee_pkg::OUT_VALUE_WIDTH-1:0]        m_tdata,  // [31:0] value
    // [0] div_by_zero, [1] underflow, [2] overflow, [3] extra_operands
    output logic [pee_pkg::FLAG_COUNT-1:0]             m_tuser
);
    import pee_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    eval_state_t                state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       flag_div_reg, flag_div_next;
    logic                       flag_under_reg, flag_under_next;
    logic                       flag_over_reg, flag_over_next;
    alu_op_t                    op_reg, op_next;
    logic                       last_reg, last_next;
    logic [VALUE_WIDTH-1:0]     opa_reg, opa_next;
    logic                       pop_empty_reg, pop_empty_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic [FLAG_COUNT-1:0]      out_flags_reg, out_flags_next;

    logic [VALUE_WIDTH-1:0]     stack_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0]     rd_data_reg;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0]     wr_data;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;

    alu_req_t                   alu_req;
    alu_rsp_t                   alu_rsp;
    logic [VALUE_WIDTH-1:0]     alu_result;
    logic [VALUE_WIDTH-1:0]     opb;

    logic                       in_fire;
    logic                       emit_fire;
    logic                       stack_empty;
    logic                       stack_full;
    logic [CNT_W-1:0]           count_dec;
    logic [SYMBOL_WIDTH-1:0]    sym_offset;
    logic [VALUE_WIDTH-1:0]     popped;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign emit_fire   = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign count_dec   = count_reg - CNT_W'(1);
    assign sym_offset  = s_tdata - CH_ZERO;
    // Data of the previous pop, zero when that pop found the stack empty.
    assign popped      = pop_empty_reg ? '0 : rd_data_reg;
    assign opb         = popped;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    pee_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (opa_reg),
        .b       (opb),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (is_operator(s_tdata)) begin
                        state_next = ST_POP_A;
                    end else if (s_tlast) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_POP_A: state_next = ST_POP_B;
            ST_POP_B: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_EXEC;
            ST_EXEC: begin
                if (alu_rsp.done) begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: state_next = ST_EMIT;
            ST_EMIT:  if (emit_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        flag_div_next   = flag_div_reg;
        flag_under_next = flag_under_reg;
        flag_over_next  = flag_over_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        opa_next        = opa_reg;
        pop_empty_next  = pop_empty_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_flags_next  = out_flags_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_data         = alu_result;
        rd_en           = 1'b0;
        rd_addr         = count_dec[ADDR_W-1:0];
        alu_req.start   = 1'b0;
        alu_req.op      = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    op_next   = decode_op(s_tdata);
                    last_next = s_tlast;
                    if (is_digit(s_tdata)) begin
                        wr_data = VALUE_WIDTH'(sym_offset[3:0]);
                        if (stack_full) begin
                            flag_over_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_POP_A, ST_POP_B, ST_FINAL: begin
                if (state_reg == ST_POP_B) begin
                    opa_next = popped;
                end
                pop_empty_next = stack_empty;
                if (stack_empty) begin
                    flag_under_next = 1'b1;
                end else begin
                    rd_en      = 1'b1;
                    count_next = count_dec;
                end
            end
            ST_LOAD: alu_req.start = 1'b1;
            ST_EXEC: begin
                if (alu_rsp.done) begin
                    flag_div_next = flag_div_reg || alu_rsp.div_zero;
                    if (stack_full) begin
                        flag_over_next = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_tvalid_next   = 1'b1;
                    out_value_next  = OUT_VALUE_WIDTH'($signed(popped));
                    out_flags_next  = {!stack_empty, flag_over_reg, flag_under_reg,
                                       flag_div_reg};
                    count_next      = '0;
                    flag_div_next   = 1'b0;
                    flag_under_next = 1'b0;
                    flag_over_next  = 1'b0;
                end
            end
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            flag_div_reg   <= 1'b0;
            flag_under_reg <= 1'b0;
            flag_over_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            flag_div_reg   <= flag_div_next;
            flag_under_reg <= flag_under_next;
            flag_over_reg  <= flag_over_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        op_reg        <= op_next;
        last_reg      <= last_next;
        opa_reg       <= opa_next;
        pop_empty_reg <= pop_empty_next;
        out_value_reg <= out_value_next;
        out_flags_reg <= out_flags_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_flags_reg;

    // The stack count never passes the stack depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond stack depth");

    // A new output beat only comes from the final step of an expression.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output beat raised outside the final step");

    // Emitting a result leaves an empty stack and clear flags.
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> (count_reg == '0) && !flag_div_reg && !flag_under_reg &&
                      !flag_over_reg)
        else $error("stack or flags not cleared after a result");

    // The arithmetic unit is started only from the load step and finishes while waited on.
    a_alu_done_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> (state_reg == ST_EXEC))
        else $error("arithmetic unit finished outside the execute step");

endmodule

`default_nettype wire

/* hw/rtl/pee_alu.sv */
`default_nettype none

module pee_alu #(
    parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire pee_pkg::alu_req_t      req,
    input  wire logic [VALUE_WIDTH-1:0] a,
    input  wire logic [VALUE_WIDTH-1:0] b,
    output pee_pkg::alu_rsp_t           rsp,
    output logic [VALUE_WIDTH-1:0]      result
);
    import pee_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    alu_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] opnd_reg, opnd_next;
    logic [VALUE_WIDTH-1:0] aux_reg, aux_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   dz_reg, dz_next;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   rem_diff;
    logic                   last_iter;

    assign last_iter = (cnt_reg == CNT_W'(1));
    assign rem_shift = {rem_reg, opnd_reg[VALUE_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, aux_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            AL_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        OP_MUL:  state_next = AL_MUL;
                        OP_DIV:  state_next = (b == '0) ? AL_DONE : AL_DIV;
                        default: state_next = AL_DONE;
                    endcase
                end
            end
            AL_MUL:  if (last_iter) state_next = AL_DONE;
            AL_DIV:  if (last_iter) state_next = AL_SIGN;
            AL_SIGN: state_next = AL_DONE;
            AL_DONE: state_next = AL_IDLE;
            default: state_next = AL_IDLE;
        endcase
    end

    always_comb begin
        acc_next  = acc_reg;
        opnd_next = opnd_reg;
        aux_next  = aux_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        case (state_reg)
            AL_IDLE: begin
                if (req.start) begin
                    cnt_next = CNT_W'(VALUE_WIDTH);
                    dz_next  = 1'b0;
                    case (req.op)
                        OP_ADD: acc_next = a + b;
                        OP_SUB: acc_next = a - b;
                        OP_MUL: begin
                            acc_next  = '0;
                            opnd_next = a;
                            aux_next  = b;
                        end
                        OP_DIV: begin
                            // Unsigned magnitudes; the most negative value maps to itself,
                            // which is its correct magnitude as an unsigned number.
                            neg_next  = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                            opnd_next = a[VALUE_WIDTH-1] ? (~a + VALUE_WIDTH'(1)) : a;
                            aux_next  = b[VALUE_WIDTH-1] ? (~b + VALUE_WIDTH'(1)) : b;
                            rem_next  = '0;
                            acc_next  = '0;
                            dz_next   = (b == '0);
                        end
                        default: acc_next = acc_reg;
                    endcase
                end
            end
            AL_MUL: begin
                if (aux_reg[0]) begin
                    acc_next = acc_reg + opnd_reg;
                end
                opnd_next = opnd_reg << 1;
                aux_next  = aux_reg >> 1;
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            AL_DIV: begin
                if (!rem_diff[VALUE_WIDTH]) begin
                    rem_next  = rem_diff[VALUE_WIDTH-1:0];
                    opnd_next = {opnd_reg[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    rem_next  = rem_shift[VALUE_WIDTH-1:0];
                    opnd_next = {opnd_reg[VALUE_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            AL_SIGN: acc_next = neg_reg ? (~opnd_reg + VALUE_WIDTH'(1)) : opnd_reg;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AL_IDLE;
        end else begin
            state_reg <= state_next;
        end
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        aux_reg  <= aux_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        dz_reg   <= dz_next;
    end

    assign rsp.done     = (state_reg == AL_DONE);
    assign rsp.div_zero = dz_reg;
    assign result       = acc_reg;

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

typedef logic [7:0] sym_q_t[$];

typedef struct {
    logic [31:0] value;
    logic [3:0]  flags;   // {extra_operands, overflow, underflow, div_by_zero}
} eval_outcome_t;

class eval_scoreboard;
    logic [31:0]   operands [pee_pkg::STACK_DEPTH_DEF];
    int            fill = 0;
    bit            div_zero_seen = 0;
    bit            underflow_seen = 0;
    bit            overflow_seen = 0;
    eval_outcome_t awaited[$];
    int            mismatches = 0;

    function void push_operand(logic [31:0] v);
        if (fill < pee_pkg::STACK_DEPTH_DEF) begin
            operands[fill] = v;
            fill++;
        end else begin
            overflow_seen = 1'b1;
        end
    endfunction

    function logic [31:0] pop_operand();
        if (fill == 0) begin
            underflow_seen = 1'b1;
            return '0;
        end
        fill--;
        return operands[fill];
    endfunction

    // Works on magnitudes so that the most negative value over minus one wraps.
    function logic [31:0] quotient_toward_zero(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if (mb == '0) begin
            div_zero_seen = 1'b1;
            return '0;
        end
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_symbol(logic [7:0] sym, bit lst);
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      r;
        bit               is_op;
        pee_pkg::alu_op_t op;
        eval_outcome_t    res;
        is_op = 1'b1;
        op = pee_pkg::OP_ADD;
        if (sym >= pee_pkg::CH_ZERO && sym <= pee_pkg::CH_NINE) begin
            push_operand(32'(sym - pee_pkg::CH_ZERO));
            is_op = 1'b0;
        end else begin
            case (sym)
                pee_pkg::CH_PLUS:  op = pee_pkg::OP_ADD;
                pee_pkg::CH_MINUS: op = pee_pkg::OP_SUB;
                pee_pkg::CH_STAR:  op = pee_pkg::OP_MUL;
                pee_pkg::CH_SLASH: op = pee_pkg::OP_DIV;
                default:           is_op = 1'b0;
            endcase
        end
        if (is_op) begin
            a = pop_operand();
            b = pop_operand();
            case (op)
                pee_pkg::OP_ADD: r = a + b;
                pee_pkg::OP_SUB: r = a - b;
                pee_pkg::OP_MUL: r = a * b;
                default:         r = quotient_toward_zero(a, b);
            endcase
            push_operand(r);
        end
        if (!lst) return;
        res.value = pop_operand();
        res.flags = {fill != 0, overflow_seen, underflow_seen, div_zero_seen};
        awaited.push_back(res);
        fill = 0;
        div_zero_seen = 1'b0;
        underflow_seen = 1'b0;
        overflow_seen = 1'b0;
    endfunction

    function void check_result(logic [31:0] value, logic [3:0] flags);
        eval_outcome_t exp_r;
        if (awaited.size() == 0) begin
            log_mismatch($sformatf("unexpected result beat: value %h flags %b", value, flags));
            return;
        end
        exp_r = awaited.pop_front();
        if (value !== exp_r.value || flags !== exp_r.flags)
            log_mismatch($sformatf("result mismatch: expected value %h flags %b, got %h %b",
                                   exp_r.value, exp_r.flags, value, flags));
    endfunction
endclass

module tb;
    import pee_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    eval_scoreboard sb;
    int unsigned    cycle_count = 0;
    bit             calm = 1'b0;
    int             counted = 0;

    prefix_expression_evaluator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 38);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] sym, input bit lst);
        if (!calm && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sb.note_symbol(sym, lst);
        if (lst || (sym >= CH_ZERO && sym <= CH_NINE) || sym == CH_PLUS || sym == CH_MINUS ||
            sym == CH_STAR || sym == CH_SLASH)
            counted++;
    endtask

    // The expression is written left to right; the block takes it right to left.
    task automatic send_expr(input sym_q_t q);
        for (int i = q.size() - 1; i >= 0; i--) send_beat(q[i], i == 0);
    endtask

    function automatic sym_q_t text_syms(string s);
        sym_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    task automatic wait_drained();
        while (sb.awaited.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    initial begin
        sym_q_t q;
        int     kind;
        int     len_cap;
        int     need;
        bit     paused;
        paused = 1'b0;
        sb = new;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_expr(text_syms("+12"));
        send_expr(text_syms("-12"));
        send_expr(text_syms("*99"));
        send_expr(text_syms("/93"));
        send_expr(text_syms("/-072"));
        send_expr(text_syms("/7-02"));
        send_expr(text_syms("/50"));
        send_expr(text_syms("+1"));
        send_expr(text_syms("12"));
        send_expr(text_syms("0"));
        // Ignored characters around a digit, the leftmost one carrying tlast; then one alone on an empty stack.
        send_expr('{8'h00, CH_ZERO + 8'd3, 8'hFF});
        send_expr('{8'h41});
        // Two to the 31st over minus one wraps back to the most negative value.
        send_expr(text_syms("/*2*8*8*8*8*8*8*8*8*88-01"));
        // One digit more than the stack holds.
        q.delete();
        repeat (STACK_DEPTH_DEF + 1) q.push_back(CH_ZERO + 8'd9);
        send_expr(q);

        s_tvalid <= 1'b0;
        wait_drained();

        while (counted < 1450) begin
            q.delete();
            kind = $urandom_range(0, 99);
            len_cap = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 15);
            need = 1;
            while (need > 0) begin
                if (q.size() < len_cap && $urandom_range(0, 1) == 1) begin
                    q.push_back(random_operator());
                    need++;
                end else begin
                    q.push_back(random_digit());
                    need--;
                end
            end
            if (kind < 15) begin
                repeat ($urandom_range(1, 3))
                    q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
            end else if (kind < 22) begin
                q.delete($urandom_range(0, q.size() - 1));
                if (q.size() == 0) q.push_back(random_operator());
            end else if (kind < 27) begin
                q.push_back(random_digit());
            end else if (kind < 30) begin
                repeat ($urandom_range(28, 40)) q.push_back(random_digit());
            end else if (kind < 32) begin
                q.delete();
                repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
            end
            calm = (counted >= 500 && counted < 750);
            if (!paused && counted >= 1000) begin
                s_tvalid <= 1'b0;
                wait_drained();
                repeat (10) @(posedge aclk);
                paused = 1'b1;
            end
            send_expr(q);
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
